FILE: hw/rtl/uaat_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uaat_pkg
// Shared types, codes and constants of the user activity aging table.
// ----------------------------------------------------------------------------
package uaat_pkg;

  localparam int unsigned SlotsDefault = 16;
  localparam int unsigned UserW        = 16;
  localparam int unsigned TimeW        = 32;
  localparam int unsigned SlotW        = 4;

  // Five minutes in milliseconds.
  localparam logic [TimeW-1:0] TimeoutReset = TimeW'(5 * 60 * 1000);

  typedef enum logic {
    OP_MARK  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ACT_REFRESH  = 3'd0,
    ACT_INSERT   = 3'd1,
    ACT_RECYCLE  = 3'd2,
    ACT_IGNORE   = 3'd3,
    ACT_ACTIVE   = 3'd4,
    ACT_EXPIRED  = 3'd5,
    ACT_NOTFOUND = 3'd6
  } action_e;

  typedef struct packed {
    op_e                     op;
    logic signed [UserW-1:0] user_id;
    logic [TimeW-1:0]        now_ms;
  } req_t;

  typedef struct packed {
    action_e          action;
    logic             is_active;
    logic [SlotW-1:0] slot;
  } res_t;

  typedef struct packed {
    logic [UserW-1:0] user;
    logic [TimeW-1:0] last_seen;
  } entry_t;

endpackage
`default_nettype wire

FILE: hw/rtl/uaat_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uaat_engine
// Table memory, valid bits and the scan/decide sequencer. One linear pass
// over the memory finds the first match, the lowest free slot and the oldest
// entry; the decide state writes back and hands out the result.
// ----------------------------------------------------------------------------
module uaat_engine
  import uaat_pkg::*;
#(
  parameter int unsigned Slots = SlotsDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [TimeW-1:0] timeout_i,
  input  wire logic             req_valid_i,
  output logic                  req_ready_o,
  input  wire req_t             req_i,
  output logic                  res_valid_o,
  input  wire logic             res_ready_i,
  output res_t                  res_o
);

  localparam int unsigned IdxW = $clog2(Slots);
  localparam logic [IdxW:0] SlotsCnt = (IdxW + 1)'(Slots);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } state_e;

  state_e           state_q;
  req_t             req_q;
  logic [IdxW:0]    cnt_q;
  logic             rd_pend_q;
  logic [IdxW-1:0]  rd_idx_q;
  entry_t           rd_data_q;
  logic             found_q;
  logic [IdxW-1:0]  match_idx_q;
  logic [TimeW-1:0] match_ts_q;
  logic             free_q;
  logic [IdxW-1:0]  free_idx_q;
  logic [IdxW-1:0]  old_idx_q;
  logic [TimeW-1:0] old_ts_q;
  logic             valid_q [Slots];
  entry_t           mem [Slots];

  logic             mem_re;
  logic             rd_hit;
  logic             rd_free;
  logic             rd_older;
  logic [UserW-1:0] user_u;
  logic [TimeW-1:0] age;
  logic             fire;
  logic             wr_en;
  logic             set_valid;
  logic             clr_valid;
  logic [IdxW-1:0]  wr_idx;
  res_t             res;

  assign user_u   = $unsigned(req_q.user_id);
  assign mem_re   = (state_q == ST_SCAN) && (cnt_q < SlotsCnt);
  assign rd_hit   = rd_pend_q && valid_q[rd_idx_q] && (rd_data_q.user == user_u);
  assign rd_free  = rd_pend_q && !valid_q[rd_idx_q];
  assign rd_older = rd_pend_q && ((rd_idx_q == '0) || (rd_data_q.last_seen < old_ts_q));
  assign age      = req_q.now_ms - match_ts_q;

  assign req_ready_o = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DECIDE);
  assign fire        = (state_q == ST_DECIDE) && res_ready_i;
  assign res_o       = res;

  // Pick the outcome from what the scan collected.
  always_comb begin
    res.action    = ACT_IGNORE;
    res.is_active = 1'b0;
    res.slot      = '0;
    wr_en         = 1'b0;
    set_valid     = 1'b0;
    clr_valid     = 1'b0;
    wr_idx        = match_idx_q;
    unique case (req_q.op)
      OP_MARK: begin
        if ((req_q.user_id == '0) || req_q.user_id[UserW-1]) begin
          res.action = ACT_IGNORE;
        end else if (found_q) begin
          res.action = ACT_REFRESH;
          res.slot   = SlotW'(match_idx_q);
          wr_en      = 1'b1;
        end else if (free_q) begin
          res.action = ACT_INSERT;
          res.slot   = SlotW'(free_idx_q);
          wr_idx     = free_idx_q;
          wr_en      = 1'b1;
          set_valid  = 1'b1;
        end else begin
          res.action = ACT_RECYCLE;
          res.slot   = SlotW'(old_idx_q);
          wr_idx     = old_idx_q;
          wr_en      = 1'b1;
          set_valid  = 1'b1;
        end
      end
      OP_QUERY: begin
        if (!found_q) begin
          res.action = ACT_NOTFOUND;
        end else if (age <= timeout_i) begin
          res.action    = ACT_ACTIVE;
          res.is_active = 1'b1;
          res.slot      = SlotW'(match_idx_q);
        end else begin
          res.action = ACT_EXPIRED;
          res.slot   = SlotW'(match_idx_q);
          clr_valid  = 1'b1;
        end
      end
      default: begin
        res.action = ACT_IGNORE;
      end
    endcase
  end

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (fire && wr_en) begin
      mem[wr_idx] <= '{user: user_u, last_seen: req_q.now_ms};
    end
    if (mem_re) begin
      rd_data_q <= mem[cnt_q[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '{default: 1'b0};
    end else if (fire) begin
      if (set_valid) begin
        valid_q[wr_idx] <= 1'b1;
      end else if (clr_valid) begin
        valid_q[match_idx_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      rd_pend_q <= 1'b0;
      found_q   <= 1'b0;
      free_q    <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (req_valid_i) begin
            cnt_q   <= '0;
            found_q <= 1'b0;
            free_q  <= 1'b0;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (mem_re) begin
            cnt_q <= cnt_q + 1'b1;
          end
          rd_pend_q <= mem_re;
          if (rd_hit) begin
            found_q <= 1'b1;
          end
          if (rd_free) begin
            free_q <= 1'b1;
          end
          // Leave once the last read has been looked at.
          if (!mem_re && !rd_pend_q) begin
            state_q <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (res_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i && (state_q == ST_IDLE)) begin
      req_q <= req_i;
    end
    rd_idx_q <= cnt_q[IdxW-1:0];
    if (rd_hit && !found_q) begin
      match_idx_q <= rd_idx_q;
      match_ts_q  <= rd_data_q.last_seen;
    end
    if (rd_free && !free_q) begin
      free_idx_q <= rd_idx_q;
    end
    if (rd_older) begin
      old_idx_q <= rd_idx_q;
      old_ts_q  <= rd_data_q.last_seen;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/user_activity_aging_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// user_activity_aging_table
// Table of user ids with last-seen timestamps, marked and queried by stream.
//
// Input stream: tuser carries the opcode (mark or query), tdata carries the
// signed user id and the current millisecond time. Output stream: one result
// item per input item; tuser carries the action code, tdata the active flag
// and the slot index.
// The timeout register is written through cfg_we_i / cfg_wdata_i; the user must
// write it only while the block is idle, as the block itself does not enforce
// this. Reset loads five minutes. For each item the table memory is read one
// entry per cycle in a single pass, the read pipeline drains, the decide state
// writes back, and the idle state takes the next item.
// The output register lets the next item be accepted while a result waits;
// if the receiver keeps stalling, the second result holds in the engine and
// no further item is taken.
// Reset clears every valid bit at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module user_activity_aging_table
  import uaat_pkg::*;
#(
  parameter int unsigned SLOTS = SlotsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,      // timeout_ms
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [47:0] s_axis_tdata_i,   // [15:0] user_id, [47:16] now_ms
  input  wire logic        s_axis_tuser_i,   // [0] opcode
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o,   // [0] is_active, [4:1] slot, [7:5] zero
  output logic [2:0]       m_axis_tuser_o    // [2:0] action
);

  logic [TimeW-1:0] timeout_q;
  req_t             req;
  logic             res_valid;
  logic             res_ready;
  res_t             res;
  logic             out_valid_q;
  res_t             out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  assign req.op      = op_e'(s_axis_tuser_i);
  assign req.user_id = s_axis_tdata_i[UserW-1:0];
  assign req.now_ms  = s_axis_tdata_i[UserW +: TimeW];

  uaat_engine #(
    .Slots(SLOTS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .timeout_i   (timeout_q),
    .req_valid_i (s_axis_tvalid_i),
    .req_ready_o (s_axis_tready_o),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register: load when empty or being drained.
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_q.slot, out_q.is_active};
  assign m_axis_tuser_o  = out_q.action;

endmodule
`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the user activity aging table.
//
// A directed table covers ignored ids, empty-table queries, the timeout
// boundary, wrapped ages, a full table and oldest-entry recycling. Random
// mark/query traffic over a small id pool then runs under several timeout
// settings. Each result item is checked against a fixed expected result or an untimed model of the table.
// ----------------------------------------------------------------------------
module tb_top;
  import uaat_pkg::*;

  localparam int unsigned Slots     = SlotsDefault;
  localparam int unsigned Latency   = Slots + 3;
  localparam int unsigned IdleLimit = 1000;
  localparam int unsigned PhaseLen  = 360;
  localparam int unsigned RowCount  = 27;

  typedef struct {
    op_e         op;
    logic [15:0] id;
    logic [31:0] now;
    bit          fixed;
    action_e     act;
    bit          active;
    logic [3:0]  slot;
  } step_row_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid  = 1'b0;
  logic [47:0] in_data   = '0;
  op_e         in_op     = OP_MARK;
  logic        s_ready;
  logic        m_valid;
  logic        m_ready   = 1'b1;
  logic [7:0]  m_data;
  logic [2:0]  m_user;

  // Untimed copy of the table and its timeout.
  bit          ent_valid [Slots];
  logic [15:0] ent_user  [Slots];
  logic [31:0] ent_seen  [Slots];
  logic [31:0] timeout_cur = TimeoutReset;

  res_t        pending_res [$];
  res_t        head_res;
  int unsigned miss_count  = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_left  = 0;
  bit          idle_on     = 1'b1;
  bit          calm        = 1'b0;
  logic [31:0] wall_ms     = '0;

  step_row_t dir_rows [RowCount] = '{
    '{OP_QUERY, 16'd5,      32'd0,          1, ACT_NOTFOUND, 0, 4'd0},
    '{OP_MARK,  16'd0,      32'd0,          1, ACT_IGNORE,   0, 4'd0},
    '{OP_MARK,  16'h8000,   32'd123,        1, ACT_IGNORE,   0, 4'd0},
    '{OP_QUERY, 16'h8000,   32'd0,          1, ACT_NOTFOUND, 0, 4'd0},
    '{OP_MARK,  16'h7FFF,   32'd1000,       1, ACT_INSERT,   0, 4'd0},
    '{OP_MARK,  16'd1,      32'hFFFF_FFFF,  1, ACT_INSERT,   0, 4'd1},
    '{OP_MARK,  16'h7FFF,   32'd2000,       1, ACT_REFRESH,  0, 4'd0},
    '{OP_QUERY, 16'h7FFF,   32'd302000,     1, ACT_ACTIVE,   1, 4'd0},
    '{OP_QUERY, 16'h7FFF,   32'd302001,     1, ACT_EXPIRED,  0, 4'd0},
    '{OP_QUERY, 16'd1,      32'd0,          1, ACT_ACTIVE,   1, 4'd1},
    '{OP_MARK,  16'd3,      32'd40,         1, ACT_INSERT,   0, 4'd0},
    '{OP_MARK,  16'd4,      32'd300,        1, ACT_INSERT,   0, 4'd2},
    '{OP_MARK,  16'd5,      32'd250,        1, ACT_INSERT,   0, 4'd3},
    '{OP_MARK,  16'd6,      32'd90,         1, ACT_INSERT,   0, 4'd4},
    '{OP_MARK,  16'd7,      32'd7,          1, ACT_INSERT,   0, 4'd5},
    '{OP_MARK,  16'd8,      32'd64,         1, ACT_INSERT,   0, 4'd6},
    '{OP_MARK,  16'd9,      32'd512,        1, ACT_INSERT,   0, 4'd7},
    '{OP_MARK,  16'd10,     32'd33,         1, ACT_INSERT,   0, 4'd8},
    '{OP_MARK,  16'd11,     32'd7,          1, ACT_INSERT,   0, 4'd9},
    '{OP_MARK,  16'd12,     32'd800,        1, ACT_INSERT,   0, 4'd10},
    '{OP_MARK,  16'd13,     32'd71,         1, ACT_INSERT,   0, 4'd11},
    '{OP_MARK,  16'd14,     32'd12,         1, ACT_INSERT,   0, 4'd12},
    '{OP_MARK,  16'd15,     32'd5000,       1, ACT_INSERT,   0, 4'd13},
    '{OP_MARK,  16'd16,     32'd18,         1, ACT_INSERT,   0, 4'd14},
    '{OP_MARK,  16'd17,     32'd9,          1, ACT_INSERT,   0, 4'd15},
    // full table, two oldest entries tie
    '{OP_MARK,  16'd20,     32'd6000,       0, ACT_IGNORE,   0, 4'd0},
    // timestamp ahead of now gives a huge age
    '{OP_QUERY, 16'd1,      32'hFFFF_FFFE,  1, ACT_EXPIRED,  0, 4'd1}
  };

  user_activity_aging_table DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (in_data),
    .s_axis_tuser_i  (in_op),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  always #5 clk = ~clk;

  // Apply one item to the table copy and return the result it yields.
  function automatic res_t table_step(input op_e op, input logic [15:0] id,
                                      input logic [31:0] now);
    res_t        r;
    int unsigned i, hit, pick;
    logic [31:0] age;
    r = '{action: ACT_IGNORE, is_active: 1'b0, slot: '0};
    hit = Slots;
    for (i = 0; i < Slots; i++) begin
      if (hit == Slots && ent_valid[i] && ent_user[i] == id) hit = i;
    end
    if (op == OP_MARK) begin
      if (id == '0 || id[15]) return r;
      if (hit < Slots) begin
        ent_seen[hit] = now;
        r.action = ACT_REFRESH;
        r.slot   = 4'(hit);
        return r;
      end
      pick = Slots;
      for (i = 0; i < Slots; i++) begin
        if (pick == Slots && !ent_valid[i]) pick = i;
      end
      if (pick < Slots) begin
        r.action = ACT_INSERT;
      end else begin
        // oldest raw timestamp, lowest index on a tie
        pick = 0;
        for (i = 1; i < Slots; i++) begin
          if (ent_seen[i] < ent_seen[pick]) pick = i;
        end
        r.action = ACT_RECYCLE;
      end
      ent_valid[pick] = 1'b1;
      ent_user[pick]  = id;
      ent_seen[pick]  = now;
      r.slot          = 4'(pick);
      return r;
    end
    if (hit == Slots) begin
      r.action = ACT_NOTFOUND;
      return r;
    end
    r.slot = 4'(hit);
    age = now - ent_seen[hit];
    if (age <= timeout_cur) begin
      r.action    = ACT_ACTIVE;
      r.is_active = 1'b1;
    end else begin
      ent_valid[hit] = 1'b0;
      r.action       = ACT_EXPIRED;
    end
    return r;
  endfunction

  task automatic report_miss(input string what);
    miss_count++;
    if (miss_count <= 100) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic send_req(input op_e op, input logic [15:0] id, input logic [31:0] now,
                          input bit fixed, input res_t want);
    res_t got;
    if (idle_on && !calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_data  <= {now, id};
    do @(posedge clk); while (!s_ready);
    got = table_step(op, id, now);
    pending_res.push_back(fixed ? want : got);
  endtask

  task automatic wait_drained();
    while (pending_res.size() != 0) @(posedge clk);
  endtask

  task automatic set_timeout(input logic [31:0] value);
    in_valid <= 1'b0;
    wait_drained();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we      <= 1'b0;
    timeout_cur  = value;
  endtask

  // Mostly ids from a small pool with advancing time; the rest is noise.
  task automatic run_phase(input int unsigned count, input logic [31:0] step_max);
    int unsigned k, pick;
    logic [15:0] base, id;
    logic [31:0] now, jump;
    op_e         op;
    base    = 16'($urandom_range(1, 32767 - 23));
    wall_ms = $urandom;
    for (k = 0; k < count; k++) begin
      if (k % 50 == 0) idle_on <= ($urandom_range(0, 2) != 0);
      pick     = $urandom_range(0, 99);
      op       = $urandom_range(0, 1) ? OP_QUERY : OP_MARK;
      wall_ms += $urandom_range(0, step_max);
      id       = base + 16'($urandom_range(0, 23));
      now      = wall_ms;
      if (pick >= 90) begin
        id  = 16'($urandom);
        now = $urandom;
      end else if (pick >= 80) begin
        jump = $urandom_range(0, step_max);
        now  = $urandom_range(0, 1) ? wall_ms - jump : wall_ms + jump;
      end
      send_req(op, id, now, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      stall_left <= 0;
      m_ready    <= 1'b1;
    end else if (idle_on && !calm && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 10);
      m_ready    <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (m_valid && m_ready) begin
      if (pending_res.size() == 0) begin
        report_miss($sformatf("unexpected item: action %0d slot %0d", m_user, m_data[4:1]));
      end else begin
        head_res = pending_res.pop_front();
        if (m_user !== head_res.action)
          report_miss($sformatf("action %0d, want %0d", m_user, head_res.action));
        if (m_data[0] !== head_res.is_active)
          report_miss($sformatf("is_active %0b, want %0b", m_data[0], head_res.is_active));
        if (m_data[4:1] !== head_res.slot)
          report_miss($sformatf("slot %0d, want %0d", m_data[4:1], head_res.slot));
      end
    end
    if (!rst_n || (in_valid && s_ready) || (m_valid && m_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[r]) begin
      send_req(dir_rows[r].op, dir_rows[r].id, dir_rows[r].now, dir_rows[r].fixed,
               '{action: dir_rows[r].act, is_active: dir_rows[r].active,
                 slot: dir_rows[r].slot});
    end
    run_phase(PhaseLen, 32'd60000);
    set_timeout(32'd0);
    run_phase(PhaseLen, 32'd2);
    set_timeout(32'hFFFF_FFFF);
    run_phase(PhaseLen, 32'd1000000);
    set_timeout($urandom);
    run_phase(PhaseLen, 32'($urandom_range(1000, 1 << 30)));
    calm <= 1'b1;
    set_timeout(32'd1000);
    run_phase(PhaseLen, 32'd400);
    in_valid <= 1'b0;
    wait_drained();
    repeat (2 * Latency) @(posedge clk);
    if (miss_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/uaat_pkg.sv
hw/rtl/uaat_engine.sv
hw/rtl/user_activity_aging_table.sv
sim/tb_top.sv
